### rtl/mtps_pkg.sv
// Shared types and codes for the muon-tau pair selector.
`default_nettype none
package mtps_pkg;

	typedef logic [1:0] func_t;

	localparam func_t FUNC_MUON = 2'd0;
	localparam func_t FUNC_TAU  = 2'd1;
	localparam func_t FUNC_END  = 2'd2;

	// one stored object: quality flag, pt or isolation, eta, phi
	typedef struct packed {
		logic               good;
		logic [15:0]        magnitude;
		logic signed [10:0] eta;
		logic signed [10:0] phi;
	} obj_t;

	// controller to datapath
	typedef struct packed {
		logic load_muon;
		logic load_tau;
		logic clear_event;
		logic clear_best;
		logic i_clear;
		logic i_inc;
		logic i_load_best;
		logic j_clear;
		logic j_inc;
		logic eval_start;
		logic upd_muon;
		logic upd_tau;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic eval_done;
		logic pair_ok;
		logic muon_empty;
		logic tau_empty;
		logic i_last;
		logic j_last;
		logic muon_found;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

### rtl/muon_tau_pair_selector.sv
// Load muons and taus: one word per cycle while the controller is idle, no result.
// End of event: each muon-tau pair checked takes a store read, a start, then the pair
// unit (divider remainder, wrap, square, compare); muons scanned until their first valid
// tau, then every tau of the chosen muon. Loads are taken while a result waits.
// Reset clears counts, the overflow flag, the output register and the two
// registers (min_sep_sq 16384, phi_half_turn 804); store contents stay undefined.
`default_nettype none
module muon_tau_pair_selector #(
	parameter int MAX_MUONS = 8,
	parameter int MAX_TAUS  = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic               good,
	input  wire logic [15:0]        magnitude,
	input  wire logic signed [10:0] eta,
	input  wire logic signed [10:0] phi,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    muon_found,
	output logic [2:0]              muon_index,
	output logic                    tau_found,
	output logic [2:0]              tau_index,
	output logic                    overflow
);

	localparam logic REG_MIN_SEP = 1'b0;
	localparam logic REG_HALF    = 1'b1;

	logic [19:0]    min_sep_sq_q;
	logic [9:0]     phi_half_turn_q;
	logic           cfg_write;
	mtps_pkg::cmd_t cmd;
	mtps_pkg::sts_t sts;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sep_sq_q    <= 20'd16384;
			phi_half_turn_q <= 10'd804;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_MIN_SEP: min_sep_sq_q    <= pwdata[19:0];
				REG_HALF:    phi_half_turn_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MIN_SEP: prdata = {12'd0, min_sep_sq_q};
			REG_HALF:    prdata = {22'd0, phi_half_turn_q};
			default:     prdata = 32'd0;
		endcase
	end

	mtps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	mtps_dp #(
		.MAX_MUONS (MAX_MUONS),
		.MAX_TAUS  (MAX_TAUS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.good          (good),
		.magnitude     (magnitude),
		.eta           (eta),
		.phi           (phi),
		.min_sep_sq    (min_sep_sq_q),
		.phi_half_turn (phi_half_turn_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.muon_found    (muon_found),
		.muon_index    (muon_index),
		.tau_found     (tau_found),
		.tau_index     (tau_index),
		.overflow      (overflow)
	);

endmodule
`default_nettype wire

### rtl/mtps_pair.sv
// Iterative pair check: wrapped phi difference, squared separation, threshold compare.
`default_nettype none
module mtps_pair (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire mtps_pkg::obj_t      muon,
	input  wire mtps_pkg::obj_t      tau,
	input  wire logic [19:0]         min_sep_sq,
	input  wire logic [9:0]          phi_half_turn,
	output logic                     done,
	output logic                     ok
);

	localparam int DIV_W        = 12;
	localparam int DIV_STEP     = 4;
	localparam int DIV_CYCLES   = DIV_W / DIV_STEP;

	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_DIV  = 3'd1;
	localparam logic [2:0] P_WRAP = 3'd2;
	localparam logic [2:0] P_SQ   = 3'd3;
	localparam logic [2:0] P_CMP  = 3'd4;

	logic [2:0]         state_q;
	logic [1:0]         div_cnt_q;
	logic [9:0]         half_q;
	logic [10:0]        dvs_q;
	logic               neg_q;
	logic               good_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   dvd_q;
	logic signed [11:0] de_q;
	logic signed [10:0] dp_q;
	logic [21:0]        de_sq_q;
	logic [19:0]        dp_sq_q;

	logic [9:0]         half_w;
	logic signed [11:0] dphi_w;
	logic [11:0]        dphi_abs_w;
	logic signed [11:0] deta_w;
	logic [DIV_W-1:0]   rem_d;
	logic [DIV_W-1:0]   dvd_d;
	logic signed [12:0] rs_w;
	logic signed [12:0] c13_w;
	logic signed [12:0] d13_w;
	logic signed [12:0] wrap_w;
	logic signed [23:0] de_prod_w;
	logic signed [21:0] dp_prod_w;
	logic [22:0]        sum_w;

	assign half_w     = (phi_half_turn == 10'd0) ? 10'd1 : phi_half_turn;
	assign dphi_w     = {tau.phi[10], tau.phi} - {muon.phi[10], muon.phi};
	assign dphi_abs_w = dphi_w[11] ? 12'(-dphi_w) : dphi_w;
	assign deta_w     = {muon.eta[10], muon.eta} - {tau.eta[10], tau.eta};

	// restoring remainder, DIV_STEP shift-subtract steps per cycle
	always_comb begin
		rem_d = rem_q;
		dvd_d = dvd_q;
		for (int k = 0; k < DIV_STEP; k++) begin
			rem_d = {rem_d[DIV_W-2:0], dvd_d[DIV_W-1]};
			dvd_d = {dvd_d[DIV_W-2:0], 1'b0};
			if (rem_d >= {1'b0, dvs_q}) begin
				rem_d = rem_d - {1'b0, dvs_q};
			end
		end
	end

	// apply the sign of the difference, then fold once into the half turn
	always_comb begin
		rs_w  = neg_q ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});
		c13_w = $signed({3'b000, half_q});
		d13_w = $signed({2'b00, dvs_q});
		if (rs_w < -c13_w) begin
			wrap_w = rs_w + d13_w;
		end else if (rs_w > c13_w) begin
			wrap_w = rs_w - d13_w;
		end else begin
			wrap_w = rs_w;
		end
	end

	assign de_prod_w = de_q * de_q;
	assign dp_prod_w = dp_q * dp_q;
	assign sum_w     = {1'b0, de_sq_q} + {3'b000, dp_sq_q};

	assign done = (state_q == P_CMP);
	assign ok   = good_q && (sum_w > {3'b000, min_sep_sq});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= P_IDLE;
			div_cnt_q <= 2'd0;
		end else begin
			unique case (state_q)
				P_IDLE: begin
					if (start) begin
						state_q   <= P_DIV;
						div_cnt_q <= 2'd0;
					end
				end
				P_DIV: begin
					if (div_cnt_q == 2'(DIV_CYCLES - 1)) begin
						state_q <= P_WRAP;
					end
					div_cnt_q <= div_cnt_q + 2'd1;
				end
				P_WRAP: state_q <= P_SQ;
				P_SQ:   state_q <= P_CMP;
				P_CMP:  state_q <= P_IDLE;
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == P_IDLE && start) begin
			half_q <= half_w;
			dvs_q  <= {half_w, 1'b0};
			neg_q  <= dphi_w[11];
			good_q <= muon.good && tau.good;
			rem_q  <= '0;
			dvd_q  <= dphi_abs_w;
			de_q   <= deta_w;
		end
		if (state_q == P_DIV) begin
			rem_q <= rem_d;
			dvd_q <= dvd_d;
		end
		if (state_q == P_WRAP) begin
			dp_q <= wrap_w[10:0];
		end
		if (state_q == P_SQ) begin
			de_sq_q <= de_prod_w[21:0];
			dp_sq_q <= dp_prod_w[19:0];
		end
	end

endmodule
`default_nettype wire

### rtl/mtps_dp.sv
// Datapath: object stores, scan indices, best-candidate tracking, output register.
`default_nettype none
module mtps_dp #(
	parameter int MAX_MUONS = 8,
	parameter int MAX_TAUS  = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mtps_pkg::cmd_t     cmd,
	output mtps_pkg::sts_t          sts,
	input  wire logic               good,
	input  wire logic [15:0]        magnitude,
	input  wire logic signed [10:0] eta,
	input  wire logic signed [10:0] phi,
	input  wire logic [19:0]        min_sep_sq,
	input  wire logic [9:0]         phi_half_turn,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    muon_found,
	output logic [2:0]              muon_index,
	output logic                    tau_found,
	output logic [2:0]              tau_index,
	output logic                    overflow
);

	localparam int M_IDX_W = (MAX_MUONS > 1) ? $clog2(MAX_MUONS) : 1;
	localparam int T_IDX_W = (MAX_TAUS > 1) ? $clog2(MAX_TAUS) : 1;
	localparam int M_CNT_W = $clog2(MAX_MUONS + 1);
	localparam int T_CNT_W = $clog2(MAX_TAUS + 1);
	localparam logic [15:0] ISO_LIMIT = 16'd63936;

	mtps_pkg::obj_t muon_mem [MAX_MUONS];
	mtps_pkg::obj_t tau_mem  [MAX_TAUS];
	mtps_pkg::obj_t muon_rd_q;
	mtps_pkg::obj_t tau_rd_q;
	mtps_pkg::obj_t new_obj;

	logic [M_CNT_W-1:0] muon_cnt_q;
	logic [T_CNT_W-1:0] tau_cnt_q;
	logic               dropped_q;
	logic [M_IDX_W-1:0] mi_q;
	logic [T_IDX_W-1:0] tj_q;
	logic               mfound_q;
	logic [M_IDX_W-1:0] midx_q;
	logic [15:0]        best_pt_q;
	logic               tfound_q;
	logic [T_IDX_W-1:0] tidx_q;
	logic [15:0]        best_iso_q;
	logic               out_valid_q;
	logic               muon_found_q;
	logic [2:0]         muon_index_q;
	logic               tau_found_q;
	logic [2:0]         tau_index_q;
	logic               overflow_q;

	logic               muon_room;
	logic               tau_room;
	logic [M_IDX_W+2:0] midx_ext;
	logic [T_IDX_W+2:0] tidx_ext;
	logic               eval_done;
	logic               pair_ok;

	assign new_obj   = {good, magnitude, eta, phi};
	assign muon_room = muon_cnt_q < M_CNT_W'(MAX_MUONS);
	assign tau_room  = tau_cnt_q < T_CNT_W'(MAX_TAUS);
	assign midx_ext  = {3'b000, midx_q};
	assign tidx_ext  = {3'b000, tidx_q};

	always_ff @(posedge clk) begin
		if (cmd.load_muon && muon_room) begin
			muon_mem[muon_cnt_q[M_IDX_W-1:0]] <= new_obj;
		end
		if (cmd.load_tau && tau_room) begin
			tau_mem[tau_cnt_q[T_IDX_W-1:0]] <= new_obj;
		end
		muon_rd_q <= muon_mem[mi_q];
		tau_rd_q  <= tau_mem[tj_q];
	end

	mtps_pair u_pair (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (cmd.eval_start),
		.muon          (muon_rd_q),
		.tau           (tau_rd_q),
		.min_sep_sq    (min_sep_sq),
		.phi_half_turn (phi_half_turn),
		.done          (eval_done),
		.ok            (pair_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			muon_cnt_q   <= '0;
			tau_cnt_q    <= '0;
			dropped_q    <= 1'b0;
			mi_q         <= '0;
			tj_q         <= '0;
			mfound_q     <= 1'b0;
			midx_q       <= '0;
			best_pt_q    <= '0;
			tfound_q     <= 1'b0;
			tidx_q       <= '0;
			best_iso_q   <= ISO_LIMIT;
			out_valid_q  <= 1'b0;
			muon_found_q <= 1'b0;
			muon_index_q <= 3'd0;
			tau_found_q  <= 1'b0;
			tau_index_q  <= 3'd0;
			overflow_q   <= 1'b0;
		end else begin
			// drop loads into a full store and flag them
			if (cmd.load_muon) begin
				if (muon_room) begin
					muon_cnt_q <= muon_cnt_q + M_CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.load_tau) begin
				if (tau_room) begin
					tau_cnt_q <= tau_cnt_q + T_CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.clear_event) begin
				muon_cnt_q <= '0;
				tau_cnt_q  <= '0;
				dropped_q  <= 1'b0;
			end

			if (cmd.i_clear) begin
				mi_q <= '0;
			end else if (cmd.i_inc) begin
				mi_q <= mi_q + M_IDX_W'(1);
			end else if (cmd.i_load_best) begin
				mi_q <= midx_q;
			end
			if (cmd.j_clear) begin
				tj_q <= '0;
			end else if (cmd.j_inc) begin
				tj_q <= tj_q + T_IDX_W'(1);
			end

			if (cmd.clear_best) begin
				mfound_q   <= 1'b0;
				midx_q     <= '0;
				best_pt_q  <= '0;
				tfound_q   <= 1'b0;
				tidx_q     <= '0;
				best_iso_q <= ISO_LIMIT;
			end
			if (cmd.upd_muon && (!mfound_q || muon_rd_q.magnitude > best_pt_q)) begin
				mfound_q  <= 1'b1;
				midx_q    <= mi_q;
				best_pt_q <= muon_rd_q.magnitude;
			end
			if (cmd.upd_tau && tau_rd_q.magnitude < best_iso_q) begin
				tfound_q   <= 1'b1;
				tidx_q     <= tj_q;
				best_iso_q <= tau_rd_q.magnitude;
			end

			if (cmd.out_load) begin
				out_valid_q  <= 1'b1;
				muon_found_q <= mfound_q;
				muon_index_q <= mfound_q ? midx_ext[2:0] : 3'd0;
				tau_found_q  <= tfound_q;
				tau_index_q  <= tfound_q ? tidx_ext[2:0] : 3'd0;
				overflow_q   <= dropped_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.eval_done  = eval_done;
		sts.pair_ok    = pair_ok;
		sts.muon_empty = (muon_cnt_q == '0);
		sts.tau_empty  = (tau_cnt_q == '0);
		sts.i_last     = (M_CNT_W'(mi_q) + M_CNT_W'(1)) == muon_cnt_q;
		sts.j_last     = (T_CNT_W'(tj_q) + T_CNT_W'(1)) == tau_cnt_q;
		sts.muon_found = mfound_q;
		sts.out_busy   = out_valid_q && out_stall;
	end

	assign out_valid  = out_valid_q;
	assign muon_found = muon_found_q;
	assign muon_index = muon_index_q;
	assign tau_found  = tau_found_q;
	assign tau_index  = tau_index_q;
	assign overflow   = overflow_q;

endmodule
`default_nettype wire

### rtl/mtps_ctrl.sv
// Controller: accepts words, sequences the muon scan and the tau scan, hands off results.
`default_nettype none
module mtps_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [1:0]      func,
	input  wire mtps_pkg::sts_t  sts,
	output mtps_pkg::cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_START  = 3'd2;
	localparam logic [2:0] ST_WAIT   = 3'd3;
	localparam logic [2:0] ST_PHASEB = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       phase_b_q;
	logic       phase_b_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		phase_b_d = phase_b_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (func)
						mtps_pkg::FUNC_MUON: cmd.load_muon = 1'b1;
						mtps_pkg::FUNC_TAU:  cmd.load_tau  = 1'b1;
						mtps_pkg::FUNC_END: begin
							cmd.clear_best = 1'b1;
							cmd.i_clear    = 1'b1;
							cmd.j_clear    = 1'b1;
							phase_b_d      = 1'b0;
							if (sts.muon_empty || sts.tau_empty) begin
								state_d = ST_FINISH;
							end else begin
								state_d = ST_READ;
							end
						end
						default: ;
					endcase
				end
			end
			// store read data lands at the end of this cycle
			ST_READ: state_d = ST_START;
			ST_START: begin
				cmd.eval_start = 1'b1;
				state_d        = ST_WAIT;
			end
			ST_WAIT: begin
				if (sts.eval_done) begin
					if (!phase_b_q) begin
						if (sts.pair_ok) begin
							cmd.upd_muon = 1'b1;
						end
						if (!sts.pair_ok && !sts.j_last) begin
							cmd.j_inc = 1'b1;
							state_d   = ST_READ;
						end else if (!sts.i_last) begin
							// advance to the next muon
							cmd.i_inc   = 1'b1;
							cmd.j_clear = 1'b1;
							state_d     = ST_READ;
						end else if (sts.muon_found || sts.pair_ok) begin
							state_d = ST_PHASEB;
						end else begin
							state_d = ST_FINISH;
						end
					end else begin
						if (sts.pair_ok) begin
							cmd.upd_tau = 1'b1;
						end
						if (sts.j_last) begin
							state_d = ST_FINISH;
						end else begin
							cmd.j_inc = 1'b1;
							state_d   = ST_READ;
						end
					end
				end
			end
			ST_PHASEB: begin
				cmd.i_load_best = 1'b1;
				cmd.j_clear     = 1'b1;
				phase_b_d       = 1'b1;
				state_d         = ST_READ;
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					cmd.out_load    = 1'b1;
					cmd.clear_event = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_b_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_b_q <= phase_b_d;
		end
	end

endmodule
`default_nettype wire

### sim/mtps_tb_pkg.sv
`timescale 1ns / 1ps
// Register addresses and codes shared by the testbench top and the checker.
package mtps_tb_pkg;

	localparam logic [2:0] ADDR_MIN_SEP   = 3'd0;
	localparam logic [2:0] ADDR_HALF_TURN = 3'd4;

	// func code with no meaning; the block drops such a word
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// 999.0 in 1/64 units; isolations at or above it never select a tau
	localparam int ISO_CUTOFF = 63936;

	localparam int MIN_SEP_RESET   = 16384;
	localparam int HALF_TURN_RESET = 804;

endpackage

### sim/mtps_checker.sv
`timescale 1ns / 1ps
// Checker: tracks register writes, predicts each pair selection and compares results.
module mtps_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         func,
	input  logic               good,
	input  logic [15:0]        magnitude,
	input  logic signed [10:0] eta,
	input  logic signed [10:0] phi,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               muon_found,
	input  logic [2:0]         muon_index,
	input  logic               tau_found,
	input  logic [2:0]         tau_index,
	input  logic               overflow,
	output int                 fail_count,
	output int                 pending
);
	import mtps_pkg::*;
	import mtps_tb_pkg::*;

	localparam int MUON_SLOTS = 8;
	localparam int TAU_SLOTS  = 8;

	typedef struct packed {
		logic       muon_found;
		logic [2:0] muon_index;
		logic       tau_found;
		logic [2:0] tau_index;
		logic       overflow;
	} pair_sel_t;

	obj_t        muon_list [MUON_SLOTS];
	obj_t        tau_list [TAU_SLOTS];
	int          muon_cnt;
	int          tau_cnt;
	logic        dropped;
	logic [19:0] min_sep;
	logic [9:0]  half_turn;
	pair_sel_t   selection_q [$];

	function automatic int wrapped_dphi(int from_phi, int to_phi);
		int c;
		int r;
		c = (half_turn == 10'd0) ? 1 : int'(half_turn);
		r = (to_phi - from_phi) % (2 * c);
		if (r < -c)
			r += 2 * c;
		else if (r > c)
			r -= 2 * c;
		return r;
	endfunction

	function automatic bit separated(obj_t m, obj_t t);
		int     de;
		int     dp;
		longint dist_sq;
		if (!m.good || !t.good)
			return 1'b0;
		de = int'($signed(m.eta)) - int'($signed(t.eta));
		dp = wrapped_dphi(int'($signed(m.phi)), int'($signed(t.phi)));
		dist_sq = longint'(de) * de + longint'(dp) * dp;
		return dist_sq > longint'(min_sep);
	endfunction

	function automatic pair_sel_t select_pair();
		pair_sel_t sel;
		bit        mfound;
		bit        tfound;
		int        midx;
		int        tidx;
		int        best_pt;
		int        best_iso;
		int        i;
		int        j;
		mfound = 1'b0;
		tfound = 1'b0;
		midx = 0;
		tidx = 0;
		best_pt = 0;
		best_iso = ISO_CUTOFF;
		// muon scan stops at its first valid tau
		for (i = 0; i < muon_cnt; i++) begin
			for (j = 0; j < tau_cnt; j++) begin
				if (separated(muon_list[i], tau_list[j])) begin
					if (!mfound || int'(muon_list[i].magnitude) > best_pt) begin
						mfound = 1'b1;
						best_pt = int'(muon_list[i].magnitude);
						midx = i;
					end
					break;
				end
			end
		end
		if (mfound) begin
			for (j = 0; j < tau_cnt; j++) begin
				if (separated(muon_list[midx], tau_list[j]) &&
				    int'(tau_list[j].magnitude) < best_iso) begin
					best_iso = int'(tau_list[j].magnitude);
					tidx = j;
					tfound = 1'b1;
				end
			end
		end
		sel.muon_found = mfound;
		sel.muon_index = mfound ? 3'(midx) : 3'd0;
		sel.tau_found  = tfound;
		sel.tau_index  = tfound ? 3'(tidx) : 3'd0;
		sel.overflow   = dropped;
		return sel;
	endfunction

	task automatic compare_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		obj_t      obj;
		pair_sel_t want;
		if (!arst_n) begin
			muon_cnt = 0;
			tau_cnt = 0;
			dropped = 1'b0;
			min_sep = 20'(MIN_SEP_RESET);
			half_turn = 10'(HALF_TURN_RESET);
			selection_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_MIN_SEP: min_sep = pwdata[19:0];
					ADDR_HALF_TURN: half_turn = pwdata[9:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (selection_q.size() == 0) begin
					$display("%0t: result expected none actual muon %0d/%0d tau %0d/%0d ovf %0d",
						$time, muon_found, muon_index, tau_found, tau_index, overflow);
					fail_count++;
				end else begin
					want = selection_q.pop_front();
					compare_field("muon_found", want.muon_found, muon_found);
					compare_field("muon_index", want.muon_index, muon_index);
					compare_field("tau_found", want.tau_found, tau_found);
					compare_field("tau_index", want.tau_index, tau_index);
					compare_field("overflow", want.overflow, overflow);
				end
			end

			if (in_valid && !in_stall) begin
				obj.good = good;
				obj.magnitude = magnitude;
				obj.eta = eta;
				obj.phi = phi;
				case (func)
					FUNC_MUON: begin
						if (muon_cnt < MUON_SLOTS)
							muon_list[muon_cnt++] = obj;
						else
							dropped = 1'b1;
					end
					FUNC_TAU: begin
						if (tau_cnt < TAU_SLOTS)
							tau_list[tau_cnt++] = obj;
						else
							dropped = 1'b1;
					end
					FUNC_END: begin
						selection_q.push_back(select_pair());
						muon_cnt = 0;
						tau_cnt = 0;
						dropped = 1'b0;
					end
					default: ;
				endcase
			end

			pending = selection_q.size();
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, register writes, event stimulus and the verdict.
module tb;
	import mtps_pkg::*;
	import mtps_tb_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 700;
	localparam int HOLD_CYCLES  = 2000;
	localparam int PHASE_WORDS  = 67;
	localparam int NUM_PHASES   = 6;
	localparam int TIMEOUT_NS   = 5_000_000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic               good;
	logic [15:0]        magnitude;
	logic signed [10:0] eta;
	logic signed [10:0] phi;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               muon_found;
	logic [2:0]         muon_index;
	logic               tau_found;
	logic [2:0]         tau_index;
	logic               overflow;

	int   fail_count;
	int   pending;
	logic word_taken = 1'b0;
	logic apb_done = 1'b0;
	int   send_idle = 0;
	int   recv_idle = 0;
	int   hold_req_cnt = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   words_sent = 0;
	int   half_turn_now = HALF_TURN_RESET;

	muon_tau_pair_selector dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.good       (good),
		.magnitude  (magnitude),
		.eta        (eta),
		.phi        (phi),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.muon_found (muon_found),
		.muon_index (muon_index),
		.tau_found  (tau_found),
		.tau_index  (tau_index),
		.overflow   (overflow)
	);

	mtps_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.good       (good),
		.magnitude  (magnitude),
		.eta        (eta),
		.phi        (phi),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.muon_found (muon_found),
		.muon_index (muon_index),
		.tau_found  (tau_found),
		.tau_index  (tau_index),
		.overflow   (overflow),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		word_taken <= in_valid && !in_stall;
		apb_done <= psel && penable && pready;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_req_cnt) begin
			hold_seen <= hold_req_cnt;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	function automatic int clamp(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic send_word(func_t f, logic g, int m, int e, int p);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		good <= g;
		magnitude <= 16'(m);
		eta <= 11'(e);
		phi <= 11'(p);
		@(negedge clk);
		while (!word_taken)
			@(negedge clk);
		if (f != FUNC_UNUSED)
			words_sent++;
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] value, logic [31:0] field_mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= ($urandom() & ~field_mask) | value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!apb_done)
			@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(int sep, int half);
		write_reg(ADDR_MIN_SEP, 32'(sep), 32'h000F_FFFF);
		write_reg(ADDR_HALF_TURN, 32'(half), 32'h0000_03FF);
		half_turn_now = half;
	endtask

	// drop valid, wait for every selection, then let trailing loads settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_object(func_t f, int cen_eta, int cen_phi, int spread, int good_pct);
		int mag;
		int e;
		int p;
		int lim;
		case ($urandom_range(3))
			0: mag = $urandom_range(65535);
			1: mag = 1000 + $urandom_range(1);
			2: mag = ISO_CUTOFF - 2 + $urandom_range(3);
			default: mag = $urandom_range(1) ? 65535 : 0;
		endcase
		e = clamp(cen_eta + int'($urandom_range(2 * spread)) - spread, -1024, 1023);
		lim = (half_turn_now == 0) ? 1 : clamp(half_turn_now, 1, 1023);
		if ($urandom_range(9) == 0)
			p = int'($urandom_range(2046)) - 1023;
		else
			p = clamp(cen_phi + int'($urandom_range(2 * spread)) - spread, -lim, lim);
		send_word(f, $urandom_range(99) < good_pct, mag, e, p);
	endtask

	task automatic run_event();
		int n_mu;
		int n_tau;
		int cen_eta;
		int cen_phi;
		int spread;
		int good_pct;
		n_mu = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5);
		n_tau = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5);
		cen_eta = int'($urandom_range(2047)) - 1024;
		cen_phi = int'($urandom_range(2046)) - 1023;
		spread = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(200);
		case ($urandom_range(9))
			0: good_pct = 0;
			1, 2: good_pct = 100;
			default: good_pct = 85;
		endcase
		while (n_mu + n_tau > 0) begin
			if ($urandom_range(24) == 0)
				send_word(FUNC_UNUSED, $urandom_range(1), $urandom_range(65535),
					int'($urandom_range(2047)), int'($urandom_range(2047)));
			if (n_tau == 0 || (n_mu > 0 && $urandom_range(1) == 1)) begin
				send_object(FUNC_MUON, cen_eta, cen_phi, spread, good_pct);
				n_mu--;
			end else begin
				send_object(FUNC_TAU, cen_eta, cen_phi, spread, good_pct);
				n_tau--;
			end
		end
		send_word(FUNC_END, $urandom_range(1), $urandom_range(65535),
			int'($urandom_range(2047)), int'($urandom_range(2047)));
	endtask

	initial begin
		#TIMEOUT_NS;
		$display("tb failed");
		$finish;
	end

	initial begin
		int k;
		int phase;
		int phase_end;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = FUNC_MUON;
		good = 1'b0;
		magnitude = '0;
		eta = '0;
		phi = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 14;
		recv_idle <= 58;

		// empty stores
		send_word(FUNC_END, 1'b0, 0, 0, 0);
		// every field at its extreme, phi difference past the half turn
		send_word(FUNC_MUON, 1'b1, 65535, -1024, -1023);
		send_word(FUNC_TAU, 1'b1, 0, 1023, 1023);
		send_word(FUNC_END, 1'b1, 65535, 1023, 1023);
		// pt tie and isolation tie; isolation at the cutoff never wins
		send_word(FUNC_MUON, 1'b1, 500, 0, 0);
		send_word(FUNC_MUON, 1'b1, 500, 0, 0);
		send_word(FUNC_TAU, 1'b1, ISO_CUTOFF, 300, 0);
		send_word(FUNC_TAU, 1'b1, ISO_CUTOFF - 1, 300, 0);
		send_word(FUNC_TAU, 1'b1, ISO_CUTOFF - 1, -300, 0);
		send_word(FUNC_END, 1'b0, 0, 0, 0);
		// bad muon, and a pair exactly on the threshold
		send_word(FUNC_MUON, 1'b0, 65535, 0, 0);
		send_word(FUNC_MUON, 1'b1, 1, 0, 0);
		send_word(FUNC_TAU, 1'b1, 0, 128, 0);
		send_word(FUNC_END, 1'b1, 0, 0, 0);
		send_word(FUNC_UNUSED, 1'b1, 16'hA5A5, -1, 1);
		// tau store overflow
		for (k = 0; k < 9; k++)
			send_word(FUNC_TAU, 1'b1, 100 + k, 400, k * 50);
		send_word(FUNC_MUON, 1'b1, 1000, -400, 0);
		send_word(FUNC_END, 1'b1, 0, 0, 0);
		drain();

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: set_config(MIN_SEP_RESET, HALF_TURN_RESET);
				1: set_config(0, 1);
				2: set_config(1048575, 1023);
				3: set_config(0, 0);
				4: set_config($urandom_range(65535), $urandom_range(1023, 1));
				default: set_config(1048575, 1);
			endcase
			case (phase / 2)
				0: begin
					send_idle = 14;
					recv_idle <= 58;
				end
				1: begin
					send_idle = 58;
					recv_idle <= 14;
				end
				default: begin
					send_idle = 0;
					recv_idle <= 0;
				end
			endcase
			if (phase == 1)
				hold_req_cnt <= hold_req_cnt + 1;
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end)
				run_event();
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
